[hw/rtl/krsc_pkg.sv]
// Package for the keyed ring substitution cipher.
// Holds the word types, tag and kind codes, and register indexes.
// Depends on nothing; used by every module of the block.
`default_nettype none

package krsc_pkg;

    // Largest number of key slots the configuration registers can hold.
    localparam int unsigned MAX_KEY_SLOTS = 16;

    // Width of the configuration register index.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned KEY_LEN_W   = 5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LEN  = 2'd2;

    // Operation kinds carried in each input word.
    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    // Output tags.
    localparam logic [7:0] TAG_KEYED   = 8'h31;
    localparam logic [7:0] TAG_SHIFTED = 8'h49;
    localparam logic [7:0] TAG_NONE    = 8'h00;

    // One input word.
    typedef struct packed {
        logic       kind;
        logic [7:0] tag;
        logic [7:0] data;
    } item_t;

    // One result word.
    typedef struct packed {
        logic [7:0] tag;
        logic [7:0] data;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/krsc_ring.sv]
// Key configuration registers and ring membership flags.
// Marks each key slot in use that holds the first occurrence of its byte.
// Depends on krsc_pkg.
`default_nettype none

module krsc_ring #(
    parameter int unsigned KEY_SLOTS = krsc_pkg::MAX_KEY_SLOTS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [krsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [krsc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic      [7:0]                          key_byte [KEY_SLOTS],
    output logic      [KEY_SLOTS-1:0]                slot_first
);

    logic [krsc_pkg::CFG_DATA_W-1:0] key_low_reg;
    logic [krsc_pkg::CFG_DATA_W-1:0] key_high_reg;
    logic [krsc_pkg::KEY_LEN_W-1:0]  key_len_reg;
    logic [2*krsc_pkg::CFG_DATA_W-1:0] key_all;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                krsc_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                krsc_pkg::REG_KEY_HIGH: key_high_reg <= cfg_wdata;
                krsc_pkg::REG_KEY_LEN:  key_len_reg  <= cfg_wdata[krsc_pkg::KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign key_all = {key_high_reg, key_low_reg};

    // Slice the key bytes out of the two key registers.
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            key_byte[i] = key_all[i*8 +: 8];
        end
    end

    // A slot is a ring member when it is in use and no earlier slot holds
    // the same byte. Slots past KEY_SLOTS never count, so a long length
    // saturates on its own.
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            logic dup;
            dup = 1'b0;
            for (int j = 0; j < i; j++) begin
                if (key_byte[j] == key_byte[i]) begin
                    dup = 1'b1;
                end
            end
            slot_first[i] = (key_len_reg > krsc_pkg::KEY_LEN_W'(i)) && !dup;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/krsc_map.sv]
// Combinational byte mapping for one word against the key ring.
// Finds the matching ring slot and selects its successor or predecessor.
// Depends on krsc_pkg.
`default_nettype none

module krsc_map #(
    parameter int unsigned KEY_SLOTS = krsc_pkg::MAX_KEY_SLOTS
) (
    input  wire krsc_pkg::item_t          item,
    input  wire logic [7:0]               key_byte [KEY_SLOTS],
    input  wire logic [KEY_SLOTS-1:0]     slot_first,
    output krsc_pkg::result_t             result
);

    localparam logic [KEY_SLOTS-1:0] SlotOne = KEY_SLOTS'(1);

    logic [KEY_SLOTS-1:0] match;
    logic [KEY_SLOTS-1:0] below_mask;
    logic [KEY_SLOTS-1:0] above_mask;
    logic [KEY_SLOTS-1:0] next_cand;
    logic [KEY_SLOTS-1:0] prev_cand;
    logic [KEY_SLOTS-1:0] next_pool;
    logic [KEY_SLOTS-1:0] prev_pool;
    logic [KEY_SLOTS-1:0] next_sel;
    logic [KEY_SLOTS-1:0] prev_sel;
    logic                 hit;
    logic [7:0]           next_byte;
    logic [7:0]           prev_byte;

    // Ring members are distinct, so at most one of them matches.
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            match[i] = slot_first[i] && (key_byte[i] == item.data);
        end
    end

    assign hit = |match;

    // Masks of slots below and above the matching slot.
    assign below_mask = match - SlotOne;
    assign above_mask = ~(match | below_mask);

    // Successor: lowest member above the match, else wrap to the lowest member.
    assign next_cand = slot_first & above_mask;
    assign next_pool = (next_cand != '0) ? next_cand : slot_first;
    assign next_sel  = next_pool & (~next_pool + SlotOne);

    // Predecessor: highest member below the match, else wrap to the highest.
    assign prev_cand = hit ? (slot_first & below_mask) : '0;
    assign prev_pool = (prev_cand != '0) ? prev_cand : slot_first;

    always_comb begin
        for (int j = 0; j < KEY_SLOTS; j++) begin
            prev_sel[j] = prev_pool[j] && ((prev_pool >> (j + 1)) == '0);
        end
    end

    // One-hot selection of the mapped key bytes.
    always_comb begin
        next_byte = '0;
        prev_byte = '0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if (next_sel[j]) begin
                next_byte = next_byte | key_byte[j];
            end
            if (prev_sel[j]) begin
                prev_byte = prev_byte | key_byte[j];
            end
        end
    end

    // Final tag and byte for the word.
    always_comb begin
        unique case (item.kind)
            krsc_pkg::KIND_ENCRYPT: begin
                if (hit) begin
                    result.tag  = krsc_pkg::TAG_KEYED;
                    result.data = next_byte;
                end else begin
                    result.tag  = krsc_pkg::TAG_SHIFTED;
                    result.data = item.data + 8'd1;
                end
            end
            default: begin
                result.tag = krsc_pkg::TAG_NONE;
                if (hit && (item.tag == krsc_pkg::TAG_KEYED)) begin
                    result.data = prev_byte;
                end else begin
                    result.data = item.data - 8'd1;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/keyed_ring_substitution_cipher_top.sv]
// Channel  | Signals                                  | Direction
// ---------+------------------------------------------+----------
// s_       | s_valid s_ready s_kind s_tag_in s_data_in | in
// m_       | m_valid m_ready m_tag_out m_data_out      | out
// cfg_     | cfg_we cfg_index cfg_wdata                | in (write only)
//
// Each accepted word is loaded into the input register; when the input stage
// advances, the mapping is captured in the output register and shows up
// there as a valid result.
// One word is accepted every cycle while the result side keeps taking words.
// Reset (aresetn, synchronous, active low) clears both stage valids and the
// key registers. A stall on m_ready backs up through both stages to s_ready.
//
// Top level of the keyed ring substitution cipher.
// Depends on krsc_pkg, krsc_ring and krsc_map.
`default_nettype none

module keyed_ring_substitution_cipher_top #(
    parameter int unsigned KEY_SLOTS = krsc_pkg::MAX_KEY_SLOTS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [krsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [krsc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_kind,
    input  wire logic [7:0]                        s_tag_in,
    input  wire logic [7:0]                        s_data_in,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [7:0]                        m_tag_out,
    output logic      [7:0]                        m_data_out
);

    logic [7:0]           key_byte [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] slot_first;

    logic                 in_valid_reg;
    krsc_pkg::item_t      in_item_reg;
    logic                 out_valid_reg;
    krsc_pkg::result_t    out_res_reg;
    krsc_pkg::result_t    map_res;
    logic                 in_advance;

    // Key registers and ring membership.
    krsc_ring #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_ring (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .key_byte   (key_byte),
        .slot_first (slot_first)
    );

    // Mapping of the registered word.
    krsc_map #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_map (
        .item       (in_item_reg),
        .key_byte   (key_byte),
        .slot_first (slot_first),
        .result     (map_res)
    );

    // The input stage moves on when the output register is free or drains.
    assign in_advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || in_advance;

    // Input register stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{kind: s_kind, tag: s_tag_in, data: s_data_in};
        end
    end

    // Output register stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance) begin
            out_res_reg <= map_res;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_tag_out  = out_res_reg.tag;
    assign m_data_out = out_res_reg.data;

`ifndef SYNTH
    // A stalled input word stays in place until the output side frees up.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !in_advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("input stage lost or changed a stalled word");

    // With no word in the input stage, a taken result leaves the output empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && m_ready && !in_valid_reg |=> !out_valid_reg)
        else $error("output stage repeated a result word");

    // An empty output register never blocks the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input side stalled with an empty output register");

    // Decrypted words always carry a zero tag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && (in_item_reg.kind == krsc_pkg::KIND_DECRYPT)
        |-> map_res.tag == krsc_pkg::TAG_NONE)
        else $error("decrypted word with a nonzero tag");

    // Encrypted words carry one of the two cipher tags.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && (in_item_reg.kind == krsc_pkg::KIND_ENCRYPT)
        |-> (map_res.tag == krsc_pkg::TAG_KEYED) || (map_res.tag == krsc_pkg::TAG_SHIFTED))
        else $error("encrypted word with an unknown tag");
`endif

endmodule

`default_nettype wire
